FILE: src/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned RemW  = 2;

  // Lead and continuation byte patterns.
  localparam logic [7:0] AsciiMask  = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Code  = 8'hF0;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;

  // Continuation counts.
  localparam logic [RemW-1:0] RemIdle  = 2'd0;
  localparam logic [RemW-1:0] RemOne   = 2'd1;
  localparam logic [RemW-1:0] RemTwo   = 2'd2;
  localparam logic [RemW-1:0] RemThree = 2'd3;

  // Decoder state carried between words.
  typedef struct packed {
    logic [RemW-1:0] remaining;
    logic [CpW-1:0]  accum;
  } dec_state_t;

  // One decode step's outcome.
  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] code_point;
    logic           decode_error;
  } dec_result_t;

endpackage

FILE: src/u8d_byte_if.sv
interface u8d_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::ByteW-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

FILE: src/u8d_char_if.sv
interface u8d_char_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CpW-1:0]   code_point;
  logic                      decode_error;

  modport source (output valid, output code_point, output decode_error, input ready);
  modport sink (input valid, input code_point, input decode_error, output ready);
endinterface

FILE: src/u8d_decode.sv
module u8d_decode (
  input  logic                      mode_i,
  input  logic [u8d_pkg::ByteW-1:0] byte_i,
  input  u8d_pkg::dec_state_t       state_i,
  output u8d_pkg::dec_state_t       state_o,
  output u8d_pkg::dec_result_t      result_o
);

  localparam int unsigned PadLead2 = u8d_pkg::CpW - 5;
  localparam int unsigned PadLead3 = u8d_pkg::CpW - 4;
  localparam int unsigned PadLead4 = u8d_pkg::CpW - 3;
  localparam int unsigned PadByte  = u8d_pkg::CpW - u8d_pkg::ByteW;

  logic [u8d_pkg::CpW-1:0] byte_ext;
  logic [u8d_pkg::CpW-1:0] shifted;

  assign byte_ext = {{PadByte{1'b0}}, byte_i};
  assign shifted  = {state_i.accum[u8d_pkg::CpW-7:0], byte_i[5:0]};

  // One step of the decoder: lead byte, continuation byte or pass-through.
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (mode_i) begin
      // Pass-through leaves any pending character untouched.
      result_o.emit       = 1'b1;
      result_o.code_point = byte_ext;
    end else if (state_i.remaining == u8d_pkg::RemIdle) begin
      if ((byte_i & u8d_pkg::AsciiMask) == '0) begin
        state_o.accum       = byte_ext;
        result_o.emit       = 1'b1;
        result_o.code_point = byte_ext;
      end else if ((byte_i & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
        state_o.accum     = {{PadLead2{1'b0}}, byte_i[4:0]};
        state_o.remaining = u8d_pkg::RemOne;
      end else if ((byte_i & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
        state_o.accum     = {{PadLead3{1'b0}}, byte_i[3:0]};
        state_o.remaining = u8d_pkg::RemTwo;
      end else if ((byte_i & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
        state_o.accum     = {{PadLead4{1'b0}}, byte_i[2:0]};
        state_o.remaining = u8d_pkg::RemThree;
      end else begin
        // A stray continuation byte or an invalid lead byte.
        state_o               = '0;
        result_o.emit         = 1'b1;
        result_o.decode_error = 1'b1;
      end
    end else if ((byte_i & u8d_pkg::ContMask) != u8d_pkg::ContCode) begin
      // A bad continuation byte is dropped and the character abandoned.
      state_o               = '0;
      result_o.emit         = 1'b1;
      result_o.decode_error = 1'b1;
    end else begin
      state_o.accum     = shifted;
      state_o.remaining = state_i.remaining - u8d_pkg::RemOne;
      if (state_i.remaining == u8d_pkg::RemOne) begin
        result_o.emit       = 1'b1;
        result_o.code_point = shifted;
      end
    end
  end

endmodule

FILE: src/utf8_stream_decoder.sv
// UTF-8 stream decoder.
// The in_i channel carries one byte per word; the out_o channel carries one
// decoded code point per word, or an error word with a zero code point when
// a bad lead or continuation byte is seen. Outside pass-through mode, lead
// bytes and inner continuation bytes produce no output word. A valid/ready
// pair on each side moves a word at a rising edge where both are high.
// An accepted byte sits in the input register, and the decode step loads
// the result register from it. Throughput is one byte per clock while the
// receiver takes results; the rate is set by the combinational decode step
// between the two registers. When the receiver stalls, the result register
// holds its word and the input register takes one more byte only if it is
// empty; then in_i.ready drops.
// cfg_we_i writes the pass-through mode bit from cfg_wdata_i; write it only
// while the block is idle. Reset clears both registers' valid flags, the
// decoder state and the mode bit, leaving the decoder waiting for a lead.
module utf8_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  u8d_byte_if.sink   in_i,
  u8d_char_if.source out_o
);

  logic                      mode_q;
  logic                      in_valid_q;
  logic [u8d_pkg::ByteW-1:0] in_byte_q;
  u8d_pkg::dec_state_t       state_q;
  u8d_pkg::dec_state_t       state_d;
  u8d_pkg::dec_result_t      result;
  logic                      out_valid_q;
  logic [u8d_pkg::CpW-1:0]   out_cp_q;
  logic                      out_err_q;
  logic                      advance;

  // The input word moves on whenever the result register is free or drained.
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !in_valid_q || advance;

  u8d_decode u_decode (
    .mode_i   (mode_q),
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  // Decoder state advances once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && result.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && result.emit) begin
      out_cp_q  <= result.code_point;
      out_err_q <= result.decode_error;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.code_point   = out_cp_q;
  assign out_o.decode_error = out_err_q;

endmodule

FILE: tb/utf8_decode_checker.sv
`timescale 1ns / 1ps

module utf8_decode_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [u8d_pkg::ByteW-1:0] in_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [u8d_pkg::CpW-1:0]   out_code_point_i,
  input  logic                      out_decode_error_i,
  output int unsigned               pending_o,
  output int unsigned               errors_o
);

  // Shadow copy of the mode bit and of the decoder state.
  logic                 pass_mode;
  u8d_pkg::dec_state_t  dec_state;
  u8d_pkg::dec_result_t expected_chars[$];
  u8d_pkg::dec_result_t predicted;
  u8d_pkg::dec_result_t oldest;

  // Drops the pending character and gives an error word.
  function automatic u8d_pkg::dec_result_t reject_byte();
    u8d_pkg::dec_result_t res;
    res = '0;
    dec_state.remaining = u8d_pkg::RemIdle;
    dec_state.accum = '0;
    res.emit = 1'b1;
    res.decode_error = 1'b1;
    return res;
  endfunction

  // Advances the shadow decoder by one byte and returns the word it causes.
  function automatic u8d_pkg::dec_result_t decode_byte(
    input logic [u8d_pkg::ByteW-1:0] b
  );
    u8d_pkg::dec_result_t res;
    res = '0;
    if (pass_mode) begin
      res.emit = 1'b1;
      res.code_point = u8d_pkg::CpW'(b);
      return res;
    end
    if (dec_state.remaining == u8d_pkg::RemIdle) begin
      if ((b & u8d_pkg::AsciiMask) == '0) begin
        dec_state.accum = u8d_pkg::CpW'(b);
        res.emit = 1'b1;
        res.code_point = u8d_pkg::CpW'(b);
      end else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
        dec_state.accum = u8d_pkg::CpW'(b & ~u8d_pkg::Lead2Mask);
        dec_state.remaining = u8d_pkg::RemOne;
      end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
        dec_state.accum = u8d_pkg::CpW'(b & ~u8d_pkg::Lead3Mask);
        dec_state.remaining = u8d_pkg::RemTwo;
      end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
        dec_state.accum = u8d_pkg::CpW'(b & ~u8d_pkg::Lead4Mask);
        dec_state.remaining = u8d_pkg::RemThree;
      end else begin
        res = reject_byte();
      end
      return res;
    end
    if ((b & u8d_pkg::ContMask) != u8d_pkg::ContCode) begin
      return reject_byte();
    end
    // Six payload bits per continuation byte; the top bits fall off.
    dec_state.accum = {dec_state.accum[u8d_pkg::CpW-7:0], b[5:0]};
    dec_state.remaining = dec_state.remaining - u8d_pkg::RemOne;
    if (dec_state.remaining == u8d_pkg::RemIdle) begin
      res.emit = 1'b1;
      res.code_point = dec_state.accum;
    end
    return res;
  endfunction

  // Predict on every accepted byte and compare every accepted word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_mode = 1'b0;
      dec_state = '0;
      expected_chars.delete();
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predicted = decode_byte(in_byte_i);
        if (predicted.emit) begin
          expected_chars.push_back(predicted);
        end
      end
      if (cfg_we_i) begin
        pass_mode = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word: code_point %h, decode_error %b",
                 out_code_point_i, out_decode_error_i);
          errors_o++;
        end else begin
          oldest = expected_chars.pop_front();
          if (out_code_point_i !== oldest.code_point) begin
            $error("code_point mismatch: expected %h, actual %h",
                   oldest.code_point, out_code_point_i);
            errors_o++;
          end
          if (out_decode_error_i !== oldest.decode_error) begin
            $error("decode_error mismatch: expected %b, actual %b",
                   oldest.decode_error, out_decode_error_i);
            errors_o++;
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

FILE: tb/tb_utf8_stream_decoder.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

  localparam int unsigned SegBytes = 120;
  localparam int unsigned HoldCycles = 80;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req;
  int unsigned chars_pending;
  int unsigned check_errors;

  u8d_byte_if in_if ();
  u8d_char_if out_if ();

  utf8_stream_decoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  utf8_decode_checker i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_if.valid),
    .in_ready_i         (in_if.ready),
    .in_byte_i          (in_if.in_byte),
    .out_valid_i        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .out_code_point_i   (out_if.code_point),
    .out_decode_error_i (out_if.decode_error),
    .pending_o          (chars_pending),
    .errors_o           (check_errors)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one byte after a random gap and waits until it is taken.
  task automatic send_byte(input logic [u8d_pkg::ByteW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Waits until every expected word is out and the pipeline has emptied.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends one random character: mostly well formed, sometimes noise or
  // a sequence cut short by a byte that is not a continuation.
  task automatic send_char(inout int unsigned count);
    int unsigned pick;
    int unsigned len;
    int unsigned conts;
    bit          broken;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_byte(8'($urandom_range(0, 127)));
      count++;
    end else if (pick >= 85 && pick < 93) begin
      send_byte(8'($urandom_range(0, 255)));
      count++;
    end else begin
      broken = (pick >= 93);
      if (broken) begin
        len = $urandom_range(2, 4);
      end else begin
        len = (pick < 45) ? 2 : (pick < 65) ? 3 : 4;
      end
      case (len)
        2: b = {3'b110, 5'($urandom)};
        3: b = {4'b1110, 4'($urandom)};
        default: b = {5'b11110, 3'($urandom)};
      endcase
      send_byte(b);
      count++;
      conts = broken ? $urandom_range(0, len - 2) : len - 1;
      repeat (conts) begin
        send_byte({2'b10, 6'($urandom)});
        count++;
      end
      if (broken) begin
        do b = 8'($urandom); while (b[7:6] == 2'b10);
        send_byte(b);
        count++;
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned sent;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.in_byte <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    hold_off_req = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ASCII extremes, one character of each length, the largest value.
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hC2); send_byte(8'hA9);
    send_byte(8'hE2); send_byte(8'h82); send_byte(8'hAC);
    send_byte(8'hF0); send_byte(8'h9F); send_byte(8'h98); send_byte(8'h80);
    send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
    // Stray continuation and five-byte lead while idle.
    send_byte(8'h80);
    send_byte(8'hF8);
    // Bad continuation: the ASCII byte is dropped, not decoded.
    send_byte(8'hC3); send_byte(8'h41);
    // Overlong form decodes as it comes.
    send_byte(8'hC0); send_byte(8'h80);
    drain();

    // Pass-through, and a character that stays pending across it.
    write_mode(1'b1);
    send_byte(8'hFF);
    send_byte(8'h80);
    drain();
    write_mode(1'b0);
    send_byte(8'hE2);
    drain();
    write_mode(1'b1);
    send_byte(8'hC3);
    drain();
    write_mode(1'b0);
    send_byte(8'h82);
    send_byte(8'hAC);

    // Random part in three idling phases; one segment each in pass-through.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 37 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        write_mode(seg == 2);
        if (ph == 2 && seg == 0) begin
          hold_off_req = 1'b1;
        end
        sent = 0;
        while (sent < SegBytes) begin
          if (seg == 2) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
          end else begin
            send_char(sent);
          end
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (check_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
